FILE: hw/rtl/srks_pkg.sv
// ----------------------------------------------------------------------------
// srks_pkg: shared types and codes for the sorted record key search unit
// Record layout, cell control group, result kinds and the key compare.
// ----------------------------------------------------------------------------
package srks_pkg;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] course;
    logic signed [31:0] score;
  } rec_t;

  // Control group broadcast from the sequencer to every cell
  typedef struct packed {
    logic insert;   // place the incoming record this cycle
    logic rotate;   // shift the ring one place toward cell 0
  } cell_ctl_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] KIND_LOAD_ACK = 2'd0;
  localparam logic [1:0] KIND_MATCH    = 2'd1;
  localparam logic [1:0] KIND_NO_MATCH = 2'd2;

  localparam logic SRC_SORTED  = 1'b0;
  localparam logic SRC_ARRIVAL = 1'b1;

  // Signed ascending key order
  function automatic logic key_less(logic signed [31:0] a, logic signed [31:0] b);
    return a < b;
  endfunction

endpackage

FILE: hw/rtl/srks_sort_cell.sv
// ----------------------------------------------------------------------------
// srks_sort_cell: one entry of the key-sorted ring
// Holds one record; on insert either keeps it, takes the new record or takes
// the left neighbor's record; on rotate takes the right neighbor's record.
// ----------------------------------------------------------------------------
module srks_sort_cell #(
  parameter int TABLE_DEPTH = 32,
  parameter int CELL_IDX    = 0
) (
  input  logic                              clk,
  input  srks_pkg::cell_ctl_t               ctl,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]  rec_count,
  input  srks_pkg::rec_t                    ins_rec,
  input  srks_pkg::rec_t                    prev_rec,
  input  logic                              prev_gt,
  input  srks_pkg::rec_t                    succ_rec,
  output srks_pkg::rec_t                    rec,
  output logic                              gt
);
  import srks_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

  rec_t rec_r;
  logic occupied;
  logic at_tail;

  assign occupied = MY_IDX < rec_count;
  assign at_tail  = MY_IDX == rec_count;
  // stored key sorts after the new one: the new record lands at or left of here
  assign gt       = occupied && key_less(ins_rec.key, rec_r.key);
  assign rec      = rec_r;

  always_ff @(posedge clk) begin
    if (ctl.insert && (gt || at_tail)) begin
      rec_r <= prev_gt ? prev_rec : ins_rec;
    end else if (ctl.rotate) begin
      rec_r <= succ_rec;
    end
  end

endmodule

FILE: hw/rtl/srks_arr_cell.sv
// ----------------------------------------------------------------------------
// srks_arr_cell: one entry of the arrival-order ring
// Takes the new record when it is the next free slot; on rotate takes the next cell's record.
// ----------------------------------------------------------------------------
module srks_arr_cell #(
  parameter int TABLE_DEPTH = 32,
  parameter int CELL_IDX    = 0
) (
  input  logic                              clk,
  input  srks_pkg::cell_ctl_t               ctl,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]  rec_count,
  input  srks_pkg::rec_t                    ins_rec,
  input  srks_pkg::rec_t                    succ_rec,
  output srks_pkg::rec_t                    rec
);
  import srks_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

  rec_t rec_r;

  assign rec = rec_r;

  always_ff @(posedge clk) begin
    if (ctl.insert && (MY_IDX == rec_count)) begin
      rec_r <= ins_rec;
    end else if (ctl.rotate) begin
      rec_r <= succ_rec;
    end
  end

endmodule

FILE: hw/rtl/sorted_record_key_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_record_key_search_unit: record table with sorted key search
// Stores up to TABLE_DEPTH records in two rings of cells, one kept sorted by
// key and one in arrival order, and answers key queries from both.
// ----------------------------------------------------------------------------
// A load writes the record into the arrival ring at the next free cell and,
// in the same cycle, every sorted cell compares its key with the new one so
// the whole ring opens a gap and the record drops in after all equal keys. A
// load into a full table is dropped and acknowledged with table_full set. A
// query keeps the input stalled until it is done: the sorted ring rotates one
// full turn past cell 0 while matching records are sent out, a closing step
// ends that list, the arrival ring then rotates one full turn, and one more
// step closes the query. Each full turn leaves the ring as it was, so no
// restore pass is needed. The input side is stalled while a query walks;
// every walk step also waits whenever the output register is full and
// stalled.
// ----------------------------------------------------------------------------
module sorted_record_key_search_unit #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [31:0] in_student_key,
  input  logic signed [31:0] in_course_code,
  input  logic signed [31:0] in_score_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic               out_source_list,
  output logic signed [31:0] out_out_key,
  output logic signed [31:0] out_out_course,
  output logic signed [31:0] out_out_score,
  output logic               out_table_full,
  output logic               out_last
);
  import srks_pkg::*;

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int STEP_W = $clog2(TABLE_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(TABLE_DEPTH);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TABLE_DEPTH - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SORT     = 3'd1;
  localparam logic [2:0] ST_SORT_END = 3'd2;
  localparam logic [2:0] ST_ARR      = 3'd3;
  localparam logic [2:0] ST_ARR_END  = 3'd4;

  // --------------------------------------------------------------------------
  // Sequencer and output registers
  // --------------------------------------------------------------------------
  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              found_r, found_nxt;     // sorted list gave a match
  logic              pend_v_r, pend_v_nxt;   // arrival match held back one step
  rec_t              pend_r, pend_nxt;
  logic signed [31:0] qkey_r, qkey_nxt;      // key under search

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r;
  logic              out_src_r;
  rec_t              out_rec_r;
  logic              out_full_r;
  logic              out_last_r;

  // one result this cycle, if any
  logic              emit;
  logic [1:0]        e_kind;
  logic              e_src;
  rec_t              e_rec;
  logic              e_full;
  logic              e_last;

  logic              adv;        // output slot free or draining this cycle
  logic              in_xfer;
  logic              step_valid; // entry now in cell 0 is below the fill count
  rec_t              ins_rec;
  cell_ctl_t         sort_ctl, arr_ctl;

  rec_t              sort_rec [TABLE_DEPTH];
  logic              sort_gt  [TABLE_DEPTH];
  rec_t              arr_rec  [TABLE_DEPTH];

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && adv);
  assign in_xfer  = in_valid && !in_stall;

  assign ins_rec.key    = in_student_key;
  assign ins_rec.course = in_course_code;
  assign ins_rec.score  = in_score_value;

  assign step_valid = CNT_W'(step_r) < count_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    step_nxt   = step_r;
    found_nxt  = found_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    qkey_nxt   = qkey_r;

    emit   = 1'b0;
    e_kind = KIND_LOAD_ACK;
    e_src  = SRC_SORTED;
    e_rec  = ins_rec;
    e_full = 1'b0;
    e_last = 1'b0;

    sort_ctl = '0;
    arr_ctl  = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_action == ACT_LOAD) begin
            // acknowledge now; drop the record when the table is full
            emit   = 1'b1;
            e_last = 1'b1;
            if (count_r == CNT_FULL) begin
              e_full = 1'b1;
            end else begin
              sort_ctl.insert = 1'b1;
              arr_ctl.insert  = 1'b1;
              count_nxt       = count_r + 1'b1;
            end
          end else begin
            qkey_nxt  = in_student_key;
            found_nxt = 1'b0;
            step_nxt  = '0;
            state_nxt = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (adv) begin
          // matches sit together in key order, so a full pass emits them
          // exactly from the lower bound onward
          sort_ctl.rotate = 1'b1;
          if (step_valid && (sort_rec[0].key == qkey_r)) begin
            emit      = 1'b1;
            e_kind    = KIND_MATCH;
            e_src     = SRC_SORTED;
            e_rec     = sort_rec[0];
            found_nxt = 1'b1;
          end
          step_nxt = step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            state_nxt = ST_SORT_END;
          end
        end
      end
      ST_SORT_END: begin
        if (adv) begin
          if (!found_r) begin
            emit         = 1'b1;
            e_kind       = KIND_NO_MATCH;
            e_src        = SRC_SORTED;
            e_rec.key    = qkey_r;
            e_rec.course = '0;
            e_rec.score  = '0;
          end
          pend_v_nxt = 1'b0;
          step_nxt   = '0;
          state_nxt  = ST_ARR;
        end
      end
      ST_ARR: begin
        if (adv) begin
          // hold each match back one step so the final one can carry last
          arr_ctl.rotate = 1'b1;
          if (step_valid && (arr_rec[0].key == qkey_r)) begin
            if (pend_v_r) begin
              emit   = 1'b1;
              e_kind = KIND_MATCH;
              e_src  = SRC_ARRIVAL;
              e_rec  = pend_r;
            end
            pend_nxt   = arr_rec[0];
            pend_v_nxt = 1'b1;
          end
          step_nxt = step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            state_nxt = ST_ARR_END;
          end
        end
      end
      ST_ARR_END: begin
        if (adv) begin
          emit   = 1'b1;
          e_src  = SRC_ARRIVAL;
          e_last = 1'b1;
          if (pend_v_r) begin
            e_kind = KIND_MATCH;
            e_rec  = pend_r;
          end else begin
            e_kind       = KIND_NO_MATCH;
            e_rec.key    = qkey_r;
            e_rec.course = '0;
            e_rec.score  = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // output register: load on a new result, clear once the transfer is taken
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    qkey_r <= qkey_nxt;
    if (emit) begin
      out_kind_r <= e_kind;
      out_src_r  <= e_src;
      out_rec_r  <= e_rec;
      out_full_r <= e_full;
      out_last_r <= e_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_source_list = out_src_r;
  assign out_out_key     = out_rec_r.key;
  assign out_out_course  = out_rec_r.course;
  assign out_out_score   = out_rec_r.score;
  assign out_table_full  = out_full_r;
  assign out_last        = out_last_r;

  // --------------------------------------------------------------------------
  // Cell rings: cell i hands to cell i-1 on rotate, cell 0 wraps to the end
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rec_t sort_prev;
    logic sort_prev_gt;

    if (i == 0) begin : g_head
      assign sort_prev    = ins_rec;
      assign sort_prev_gt = 1'b0;
    end else begin : g_body
      assign sort_prev    = sort_rec[i-1];
      assign sort_prev_gt = sort_gt[i-1];
    end

    srks_sort_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_IDX    (i)
    ) u_sort_cell (
      .clk       (clk),
      .ctl       (sort_ctl),
      .rec_count (count_r),
      .ins_rec   (ins_rec),
      .prev_rec  (sort_prev),
      .prev_gt   (sort_prev_gt),
      .succ_rec  (sort_rec[(i + 1) % TABLE_DEPTH]),
      .rec       (sort_rec[i]),
      .gt        (sort_gt[i])
    );

    srks_arr_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_IDX    (i)
    ) u_arr_cell (
      .clk       (clk),
      .ctl       (arr_ctl),
      .rec_count (count_r),
      .ins_rec   (ins_rec),
      .succ_rec  (arr_rec[(i + 1) % TABLE_DEPTH]),
      .rec       (arr_rec[i])
    );
  end

endmodule
